// ----- hdl/fsf_pkg.sv -----
// Shared types, widths and helpers for the frame store drawing engine.
`default_nettype none

package fsf_pkg;

    localparam int ACT_W   = 2;   // command code
    localparam int POS_W   = 13;  // signed position fields
    localparam int LEN_W   = 12;  // width, height, radius
    localparam int PIX_W   = 32;  // pixel word
    localparam int CW      = 13;  // clipped screen coordinate, 0..screen width or height
    localparam int DW      = 14;  // signed coordinate sums and differences
    localparam int SQ_W    = 2 * DW;

    localparam int DEF_SCREEN_WIDTH  = 256;
    localparam int DEF_SCREEN_HEIGHT = 256;

    typedef enum logic [ACT_W-1:0] {
        ACT_FILL    = 2'd0,
        ACT_OUTLINE = 2'd1,
        ACT_CIRCLE  = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    // Clamp a signed coordinate into 0..hi.
    function automatic logic [CW-1:0] fsf_clip(input logic signed [DW-1:0] v,
                                               input logic [CW-1:0] hi);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({1'b0, hi})) begin
            res = hi;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/framebuffer_shape_fill.sv -----
// Frame store with rectangle, outline, disc fill and pixel read commands.
//
// Input channel: i_in_valid / o_in_stall carry one command word per handshake.
// Output channel: o_out_valid / i_out_stall return exactly one word per
// command: the pixel for a read (zero off-screen), zero for draw commands.
// A command is taken only while the engine is idle; o_in_stall stays high
// until its result has been loaded into the output register.
// Sequence: each box pass clips its bounds, then takes the row base from the
// shared multiplier; a disc also forms dx^2, dy^2 and r^2 there. The scan then
// writes one pixel per cycle through the single store write port, and S_DONE
// loads the output register once that register is free. After S_DONE the engine
// is back in S_IDLE and can take the next command. An outline runs an edge
// pass per side; an off-screen pass ends in S_MUL0, after its clip. A read
// clips, takes the row base, then reads the store in S_RD and S_RDW.
// The next command may be accepted while a result still waits in the output
// register; the engine then holds its own result until that word is taken.
// Reset clears the sequencer and the output valid; the store is not cleared,
// so pixels read before they are written return unspecified data.
`default_nettype none

module framebuffer_shape_fill #(
    parameter int SCREEN_WIDTH  = fsf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fsf_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [fsf_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [fsf_pkg::POS_W-1:0]  i_x_pos,
    input  wire logic signed [fsf_pkg::POS_W-1:0]  i_y_pos,
    input  wire logic [fsf_pkg::LEN_W-1:0]         i_box_width,
    input  wire logic [fsf_pkg::LEN_W-1:0]         i_box_height,
    input  wire logic [fsf_pkg::LEN_W-1:0]         i_radius,
    input  wire logic [fsf_pkg::PIX_W-1:0]         i_paint_colour,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [fsf_pkg::PIX_W-1:0]              o_read_data
);
    import fsf_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] W_C = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0] H_C = CW'(SCREEN_HEIGHT);
    localparam logic [1:0] LAST_PASS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_SCAN,
        S_RD,
        S_RDW,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_action                 r_act;
    logic [1:0]              r_pass;
    logic signed [POS_W-1:0] r_x, r_y;
    logic [LEN_W-1:0]        r_w, r_h, r_r;
    logic [PIX_W-1:0]        r_colour;
    logic [CW-1:0]           r_xs, r_xe, r_ys, r_ye;
    logic [CW-1:0]           r_px, r_py;
    logic [AW-1:0]           r_row;
    logic signed [DW-1:0]    r_dx, r_dx0, r_dy;
    logic [SQ_W-1:0]         r_dxsq, r_dx0sq, r_dysq, r_r2;
    logic [PIX_W-1:0]        r_result;
    logic                    r_out_valid;
    logic [PIX_W-1:0]        r_read_data;
    logic [PIX_W-1:0]        r_rd_q;

    logic [PIX_W-1:0] mem [DEPTH];

    logic signed [DW-1:0]  x14, y14, w14, h14, r14, one14;
    logic signed [DW-1:0]  xlo, xhi, ylo, yhi;
    logic signed [DW-1:0]  mul_a, mul_b;
    logic signed [SQ_W-1:0] mul_p;
    logic [AW-1:0]         addr;
    logic [SQ_W:0]         dsq_sum;
    logic                  hit, we, col_last, row_last, box_empty, more_passes;
    logic                  accept, out_free;
    logic [SQ_W-1:0]       dx_step, dy_step;

    assign x14   = {r_x[POS_W-1], r_x};
    assign y14   = {r_y[POS_W-1], r_y};
    assign w14   = $signed({2'b00, r_w});
    assign h14   = $signed({2'b00, r_h});
    assign r14   = $signed({2'b00, r_r});
    assign one14 = DW'(1);

    // box of the current pass before clipping
    always_comb begin
        xlo = x14;
        xhi = x14 + w14;
        ylo = y14;
        yhi = y14 + h14;
        case (r_act)
            ACT_FILL: begin
                xhi = x14 + w14;
            end
            ACT_CIRCLE: begin
                xlo = x14 - r14;
                xhi = x14 + r14;
                ylo = y14 - r14;
                yhi = y14 + r14;
            end
            ACT_READ: begin
                xhi = x14 + one14;
                yhi = y14 + one14;
            end
            ACT_OUTLINE: begin
                case (r_pass)
                    2'd0: begin
                        yhi = y14 + one14;
                    end
                    2'd1: begin
                        ylo = y14 + h14 - one14;
                    end
                    2'd2: begin
                        xhi = x14 + one14;
                    end
                    default: begin
                        xlo = x14 + w14 - one14;
                    end
                endcase
            end
            default: begin
                xhi = x14 + w14;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_MUL0: begin
                mul_a = $signed({1'b0, r_ys});
                mul_b = $signed({1'b0, W_C});
            end
            S_MUL1: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            S_MUL2: begin
                mul_a = r_dy;
                mul_b = r_dy;
            end
            default: begin
                mul_a = r14;
                mul_b = r14;
            end
        endcase
    end

    fsf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign addr        = r_row + AW'(r_px);
    assign dsq_sum     = {1'b0, r_dxsq} + {1'b0, r_dysq};
    assign hit         = (r_act != ACT_CIRCLE) || (dsq_sum < {1'b0, r_r2});
    assign we          = (r_state == S_SCAN) && hit;
    assign col_last    = (r_px + CW'(1)) == r_xe;
    assign row_last    = (r_py + CW'(1)) == r_ye;
    assign box_empty   = (r_xs >= r_xe) || (r_ys >= r_ye);
    assign more_passes = (r_act == ACT_OUTLINE) && (r_pass != LAST_PASS);
    // (d+1)^2 - d^2 = 2d + 1
    assign dx_step     = {{(SQ_W-DW-1){r_dx[DW-1]}}, r_dx, 1'b1};
    assign dy_step     = {{(SQ_W-DW-1){r_dy[DW-1]}}, r_dy, 1'b1};

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= r_colour;
        end
        r_rd_q <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act    <= t_action'(i_action);
                        r_x      <= i_x_pos;
                        r_y      <= i_y_pos;
                        r_w      <= i_box_width;
                        r_h      <= i_box_height;
                        r_r      <= i_radius;
                        r_colour <= i_paint_colour;
                        r_pass   <= 2'd0;
                        r_result <= '0;
                        if (t_action'(i_action) == ACT_OUTLINE &&
                            (i_box_width == '0 || i_box_height == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    r_xs    <= fsf_clip(xlo, W_C);
                    r_xe    <= fsf_clip(xhi, W_C);
                    r_ys    <= fsf_clip(ylo, H_C);
                    r_ye    <= fsf_clip(yhi, H_C);
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_px  <= r_xs;
                    r_py  <= r_ys;
                    r_dx  <= $signed({1'b0, r_xs}) - x14;
                    r_dx0 <= $signed({1'b0, r_xs}) - x14;
                    r_dy  <= $signed({1'b0, r_ys}) - y14;
                    if (box_empty) begin
                        if (more_passes) begin
                            r_pass  <= r_pass + 2'd1;
                            r_state <= S_PASS;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_row <= mul_p[AW-1:0];
                    if (r_act == ACT_READ) begin
                        r_state <= S_RD;
                    end else if (r_act == ACT_CIRCLE) begin
                        r_state <= S_MUL2;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_MUL2: begin
                    r_dxsq  <= mul_p;
                    r_dx0sq <= mul_p;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_dysq  <= mul_p;
                    r_state <= S_MUL4;
                end
                S_MUL4: begin
                    r_r2    <= mul_p;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (col_last) begin
                        r_px   <= r_xs;
                        r_dx   <= r_dx0;
                        r_dxsq <= r_dx0sq;
                        if (row_last) begin
                            if (more_passes) begin
                                r_pass  <= r_pass + 2'd1;
                                r_state <= S_PASS;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_py   <= r_py + CW'(1);
                            r_row  <= r_row + AW'(SCREEN_WIDTH);
                            r_dy   <= r_dy + one14;
                            r_dysq <= r_dysq + dy_step;
                        end
                    end else begin
                        r_px   <= r_px + CW'(1);
                        r_dx   <= r_dx + one14;
                        r_dxsq <= r_dxsq + dx_step;
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_result <= r_rd_q;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_read_data <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

// ----- hdl/fsf_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none

module fsf_mul (
    input  wire logic                            i_clk,
    input  wire logic signed [fsf_pkg::DW-1:0]   i_a,
    input  wire logic signed [fsf_pkg::DW-1:0]   i_b,
    output logic signed [fsf_pkg::SQ_W-1:0]      o_p
);
    import fsf_pkg::*;

    logic signed [SQ_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- hdl/fsf_check.sv -----
// Port-level checker for the frame store drawing engine, bound to the top level.
`default_nettype none

module fsf_check (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [fsf_pkg::PIX_W-1:0]    o_read_data
);
    import fsf_pkg::*;

    logic       in_acc, out_acc;
    logic [1:0] r_open;  // commands taken whose word is not yet delivered

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 2'd0;
        end else begin
            r_open <= r_open + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not cleared after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("engine took a command and did not go busy");

    a_no_spurious_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_open != 2'd0))
        else $error("result word without an open command");

    a_two_open_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open == 2'd2) |-> o_in_stall)
        else $error("third command could be taken with two open");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_data)))
        else $error("stalled result word changed");

endmodule

bind framebuffer_shape_fill fsf_check u_fsf_check (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the frame store drawing engine (fill, outline, disc, read).
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsf_pkg::*;

    localparam int SCR_W = DEF_SCREEN_WIDTH;
    localparam int SCR_H = DEF_SCREEN_HEIGHT;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_action                  i_action = ACT_READ;
    logic signed [POS_W-1:0]  i_x_pos = '0;
    logic signed [POS_W-1:0]  i_y_pos = '0;
    logic [LEN_W-1:0]         i_box_width = '0;
    logic [LEN_W-1:0]         i_box_height = '0;
    logic [LEN_W-1:0]         i_radius = '0;
    logic [PIX_W-1:0]         i_paint_colour = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [PIX_W-1:0]         o_read_data;

    // shadow copy of the frame store and the words still owed by the block
    logic [PIX_W-1:0] shadow_pixels [SCR_W*SCR_H];
    logic [PIX_W-1:0] pending_words [$];
    logic [PIX_W-1:0] want_word;

    int err_count = 0;
    bit idle_on = 1'b1;
    int act_count [4];
    int offscreen_reads = 0;

    framebuffer_shape_fill dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_radius       (i_radius),
        .i_paint_colour (i_paint_colour),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // fill, circle and outline scans all clip their bounds to 0..hi
    function automatic int clip_to(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit on_screen(int px, int py);
        return px >= 0 && px < SCR_W && py >= 0 && py < SCR_H;
    endfunction

    function automatic void plot_pixel(int px, int py, logic [PIX_W-1:0] c);
        if (on_screen(px, py))
            shadow_pixels[py*SCR_W + px] = c;
    endfunction

    function automatic void paint_box(int x, int y, int w, int h, logic [PIX_W-1:0] c);
        int x0, x1, y0, y1;
        x0 = clip_to(x, SCR_W);
        x1 = clip_to(x + w, SCR_W);
        y0 = clip_to(y, SCR_H);
        y1 = clip_to(y + h, SCR_H);
        for (int py = y0; py < y1; py++)
            for (int px = x0; px < x1; px++)
                plot_pixel(px, py, c);
    endfunction

    function automatic void paint_frame(int x, int y, int w, int h, logic [PIX_W-1:0] c);
        int x0, x1, y0, y1;
        x0 = clip_to(x, SCR_W);
        x1 = clip_to(x + w, SCR_W);
        y0 = clip_to(y, SCR_H);
        y1 = clip_to(y + h, SCR_H);
        if (w == 0 || h == 0)
            return;
        // edge rows and columns use the unclipped position
        for (int i = x0; i < x1; i++) begin
            plot_pixel(i, y, c);
            plot_pixel(i, y + h - 1, c);
        end
        for (int i = y0; i < y1; i++) begin
            plot_pixel(x, i, c);
            plot_pixel(x + w - 1, i, c);
        end
    endfunction

    function automatic void paint_disc(int x, int y, int r, logic [PIX_W-1:0] c);
        int x0, x1, y0, y1;
        longint r2, dx, dy;
        x0 = clip_to(x - r, SCR_W);
        x1 = clip_to(x + r, SCR_W);
        y0 = clip_to(y - r, SCR_H);
        y1 = clip_to(y + r, SCR_H);
        r2 = longint'(r) * r;
        for (int py = y0; py < y1; py++) begin
            dy = longint'(py) - y;
            for (int px = x0; px < x1; px++) begin
                dx = longint'(px) - x;
                if (dx*dx + dy*dy < r2)
                    plot_pixel(px, py, c);
            end
        end
    endfunction

    // applies one command to the shadow store, returns the word the block owes
    function automatic logic [PIX_W-1:0] draw_and_predict(t_action act, int x, int y, int w,
                                                          int h, int r, logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] rd;
        rd = '0;
        act_count[act]++;
        case (act)
            ACT_FILL:    paint_box(x, y, w, h, c);
            ACT_OUTLINE: paint_frame(x, y, w, h, c);
            ACT_CIRCLE:  paint_disc(x, y, r, c);
            default: begin
                if (on_screen(x, y))
                    rd = shadow_pixels[y*SCR_W + x];
                else
                    offscreen_reads++;
            end
        endcase
        return rd;
    endfunction

    task automatic send_cmd(t_action act, int x, int y, int w, int h, int r,
                            logic [PIX_W-1:0] c);
        int gap;
        logic signed [POS_W-1:0] xf, yf;
        logic [LEN_W-1:0] wf, hf, rf;
        xf = x[POS_W-1:0];
        yf = y[POS_W-1:0];
        wf = w[LEN_W-1:0];
        hf = h[LEN_W-1:0];
        rf = r[LEN_W-1:0];
        gap = idle_on ? $urandom_range(19, 0) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action       <= act;
        i_x_pos        <= xf;
        i_y_pos        <= yf;
        i_box_width    <= wf;
        i_box_height   <= hf;
        i_radius       <= rf;
        i_paint_colour <= c;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_words.push_back(draw_and_predict(act, int'(xf), int'(yf), int'(wf),
                                                 int'(hf), int'(rf), c));
    endtask

    // receiver: one random hold-off per word while idle_on is set
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = idle_on ? $urandom_range(19, 0) : 0;
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_words.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word: expected none, actual %h", $time, o_read_data);
            end else begin
                want_word = pending_words.pop_front();
                if (o_read_data !== want_word) begin
                    err_count++;
                    $display("%0t: read_data mismatch: expected %h, actual %h",
                             $time, want_word, o_read_data);
                end
            end
        end
    end

    // every pixel gets written first, so no later read can hit an unwritten word
    task automatic test_clear_screen();
        send_cmd(ACT_FILL, 0, 0, SCR_W, SCR_H, 0, $urandom);
        send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
        send_cmd(ACT_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0);
    endtask

    task automatic test_fill_rect();
        send_cmd(ACT_FILL, -4096, -4096, 4095, 4095, 4095, $urandom);
        send_cmd(ACT_FILL, 4095, 4095, 4095, 4095, 0, $urandom);
        send_cmd(ACT_FILL, 250, 5, 0, 10, 7, $urandom);
        send_cmd(ACT_FILL, 250, -3, 20, 8, 0, 32'h0000_0000);
        send_cmd(ACT_READ, SCR_W - 1, 2, 0, 0, 0, $urandom);
    endtask

    task automatic test_outline();
        send_cmd(ACT_OUTLINE, 10, 10, 20, 12, 0, 32'hFFFF_FFFF);
        send_cmd(ACT_OUTLINE, -5, 250, 300, 10, 0, $urandom);
        send_cmd(ACT_OUTLINE, 100, 100, 0, 5, 0, $urandom);
        send_cmd(ACT_OUTLINE, 40, 40, 1, 1, 0, $urandom);
        send_cmd(ACT_OUTLINE, -4096, -4096, 4095, 4095, 0, $urandom);
        // every edge lands just outside the screen
        send_cmd(ACT_OUTLINE, -1, -1, SCR_W + 2, SCR_H + 2, 0, $urandom);
        send_cmd(ACT_READ, 10, 10, 0, 0, 0, 0);
    endtask

    task automatic test_disc();
        send_cmd(ACT_CIRCLE, 128, 128, 9, 9, 0, $urandom);
        send_cmd(ACT_CIRCLE, 0, 0, 0, 0, 1, $urandom);
        send_cmd(ACT_CIRCLE, 200, -3, 0, 0, 9, $urandom);
        // scans the whole screen; columns from x = 3 on fall wholly inside, column 0 stays outside
        send_cmd(ACT_CIRCLE, 4095, 128, 0, 0, 4095, $urandom);
        send_cmd(ACT_READ, SCR_W - 1, 128, 0, 0, 0, 0);
        send_cmd(ACT_CIRCLE, -4096, -4096, 0, 0, 4095, $urandom);
    endtask

    task automatic test_read_edges();
        send_cmd(ACT_READ, -1, 0, 4095, 4095, 4095, 32'hFFFF_FFFF);
        send_cmd(ACT_READ, SCR_W, 5, 0, 0, 0, 0);
        send_cmd(ACT_READ, -4096, 4095, 0, 0, 0, 0);
        send_cmd(ACT_READ, 3, -4096, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n_items);
        int sel;
        t_action act;
        int x, y, w, h, r;
        for (int k = 0; k < n_items; k++) begin
            // alternate stretches with and without idle cycles
            if (k % 25 == 0)
                idle_on = (k / 25) % 2 == 0;
            sel = $urandom_range(99, 0);
            if (sel < 8) begin
                act = t_action'($urandom_range(3, 0));
                x = int'($urandom_range(8191, 0)) - 4096;
                y = int'($urandom_range(8191, 0)) - 4096;
                w = $urandom_range(4095, 0);
                h = $urandom_range(4095, 0);
                r = $urandom_range(4095, 0);
            end else if (sel < 12) begin
                // large draw near the origin, kept rare since it can scan most of the screen
                act = ($urandom_range(1, 0) != 0) ? ACT_FILL : ACT_CIRCLE;
                x = int'($urandom_range(40, 0)) - 20;
                y = int'($urandom_range(40, 0)) - 20;
                w = $urandom_range(4095, 230);
                h = $urandom_range(4095, 230);
                r = $urandom_range(4095, 150);
            end else begin
                act = ($urandom_range(9, 0) < 4) ? ACT_READ : t_action'($urandom_range(2, 0));
                x = int'($urandom_range(SCR_W + 31, 0)) - 32;
                y = int'($urandom_range(SCR_H + 31, 0)) - 32;
                w = $urandom_range(48, 0);
                h = $urandom_range(48, 0);
                r = $urandom_range(32, 0);
            end
            send_cmd(act, x, y, w, h, r, $urandom);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
        foreach (act_count[i]) act_count[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clear_screen();
        test_fill_rect();
        test_outline();
        test_disc();
        test_read_edges();
        test_random(75);

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
        end

        $display("Commands sent: %0d fill, %0d outline, %0d disc, %0d read (%0d off-screen)",
                 act_count[ACT_FILL], act_count[ACT_OUTLINE], act_count[ACT_CIRCLE],
                 act_count[ACT_READ], offscreen_reads);
        $display("Clipping, empty shapes and random handshake gaps on both sides exercised");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // every command a full-screen disc with the longest gaps still ends under 80 ms
    initial begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
